@@ hdl/soiir_pkg.sv @@
// shared types and constants for the second-order iir plant model
`default_nettype none

package soiir_pkg;

  localparam int Y_WIDTH        = 40;
  localparam int FRAC_SHIFT     = 24;
  localparam int PROD_WIDTH     = 60;
  localparam int OUT_WIDTH      = 32;
  localparam int HALF_WIDTH     = Y_WIDTH / 2;
  localparam int ACC_WIDTH      = PROD_WIDTH + 3;
  localparam int NUM_TERMS      = 5;
  localparam int APB_DATA_WIDTH = 64;
  localparam int APB_ADDR_WIDTH = 6;
  localparam int IDX_WIDTH      = 4;

  typedef logic [IDX_WIDTH-1:0] idx_t;

  localparam idx_t ISSUE_LAST = idx_t'(2 * NUM_TERMS - 1);

  typedef enum logic [2:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_e;

  localparam logic signed [63:0] RST_B0   = 64'sd67252460192;
  localparam logic signed [63:0] RST_B1   = -64'sd67252460192;
  localparam logic signed [63:0] RST_B2   = 64'sd3;
  localparam logic signed [63:0] RST_A1   = 64'sd16039202;
  localparam logic signed [63:0] RST_A2   = 64'sd737997;
  localparam logic signed [63:0] RST_GAIN = 64'sd4194;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_FDRAIN,
    ST_YSTORE,
    ST_GAIN,
    ST_GDRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic valid;
    logic half;
    logic clr_acc;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } mac_stat_t;

endpackage

`default_nettype wire

@@ hdl/soiir_mac.sv @@
// shared half-width multiplier with product assembly, floor shift, clip and accumulate
`default_nettype none

module soiir_mac #(
  parameter int COEF_WIDTH = 40
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  soiir_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [COEF_WIDTH-1:0]           coef_i,
  input  logic signed [soiir_pkg::Y_WIDTH-1:0]   operand_i,
  output logic signed [soiir_pkg::ACC_WIDTH-1:0] acc_o,
  output soiir_pkg::mac_stat_t                   stat_o
);
  import soiir_pkg::*;

  localparam int MUL_WIDTH  = COEF_WIDTH + HALF_WIDTH + 1;
  localparam int FULL_WIDTH = COEF_WIDTH + Y_WIDTH;
  localparam int SH_WIDTH   = FULL_WIDTH - FRAC_SHIFT;

  logic signed [HALF_WIDTH:0]     chunk;
  logic signed [MUL_WIDTH-1:0]    mul_d, mul_q;
  logic                           v1_q, half1_q, v2_q;
  logic signed [FULL_WIDTH-1:0]   lo_q, full_d, full_q;
  logic signed [SH_WIDTH-1:0]     shifted;
  logic signed [PROD_WIDTH-1:0]   term;
  logic                           term_ovf;
  logic signed [ACC_WIDTH-1:0]    acc_d, acc_q;

  // low half unsigned, high half signed
  assign chunk = ctrl_i.half ? {operand_i[Y_WIDTH-1], operand_i[Y_WIDTH-1:HALF_WIDTH]}
                             : {1'b0, operand_i[HALF_WIDTH-1:0]};
  assign mul_d = MUL_WIDTH'(coef_i) * MUL_WIDTH'(chunk);

  assign full_d  = lo_q + (FULL_WIDTH'(mul_q) <<< HALF_WIDTH);
  assign shifted = full_q[FULL_WIDTH-1:FRAC_SHIFT];

  if (SH_WIDTH > PROD_WIDTH) begin : g_clip
    logic [SH_WIDTH-PROD_WIDTH:0] top;
    assign top      = shifted[SH_WIDTH-1:PROD_WIDTH-1];
    assign term_ovf = !(&top) && (|top);
    assign term     = !term_ovf ? shifted[PROD_WIDTH-1:0] :
                      shifted[SH_WIDTH-1] ? {1'b1, {(PROD_WIDTH-1){1'b0}}}
                                          : {1'b0, {(PROD_WIDTH-1){1'b1}}};
  end else begin : g_noclip
    assign term_ovf = 1'b0;
    assign term     = PROD_WIDTH'(shifted);
  end

  assign acc_d = acc_q + ACC_WIDTH'(term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      half1_q <= 1'b0;
      v2_q    <= 1'b0;
      acc_q   <= '0;
    end else begin
      v1_q    <= ctrl_i.valid;
      half1_q <= ctrl_i.half;
      v2_q    <= v1_q && half1_q;
      if (ctrl_i.clr_acc) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      mul_q <= mul_d;
    end
    if (v1_q && !half1_q) begin
      lo_q <= FULL_WIDTH'(mul_q);
    end
    if (v1_q && half1_q) begin
      full_q <= full_d;
    end
  end

  assign acc_o       = acc_q;
  assign stat_o.busy = v1_q | v2_q;
  assign stat_o.ovf  = v2_q & term_ovf;

endmodule

`default_nettype wire

@@ hdl/second_order_iir_plant_model.sv @@
// top level of the second-order direct form i iir plant model
// usage:
//   input channel carries sample_in (signed q8.16) and clear_history; a transfer
//   happens when in_valid_i is high and in_stall_o is low. in_stall_o is high
//   while an item is being worked on.
//   output channel carries sample_out (signed q16.16, saturated) and saturated;
//   a transfer happens when out_valid_o is high and out_stall_i is low.
//   the input is stalled from the transfer until the result is loaded into the
//   output register. the work per item is set by the single 40x21-bit multiplier,
//   which issues twelve half products (five filter terms and the gain, two
//   halves each) plus two three-stage drains and the clip steps.
//   a finished result waits in the output register; a new item may be taken
//   while it waits, and its result is held back until the old one is taken.
//   coefficients and gain sit in an apb register bank, 8 bytes per register,
//   to be written only while the block is idle; the block does not enforce it.
//   reset loads the default coefficients of the first plant and zeroes the
//   history; clear_history zeroes it for one item before that item is used.
`default_nettype none

module second_order_iir_plant_model #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 40
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [soiir_pkg::APB_ADDR_WIDTH-1:0]      paddr,
  input  logic [soiir_pkg::APB_DATA_WIDTH-1:0]      pwdata,
  output logic [soiir_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                      pready,
  input  logic signed [SAMPLE_WIDTH-1:0]            sample_in_i,
  input  logic                                      clear_history_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  output logic signed [soiir_pkg::OUT_WIDTH-1:0]    sample_out_o,
  output logic                                      saturated_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i
);
  import soiir_pkg::*;

  logic signed [COEF_WIDTH-1:0]   coef_b0_q, coef_b1_q, coef_b2_q;
  logic signed [COEF_WIDTH-1:0]   coef_a1_q, coef_a2_q, gain_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, x1_q, x2_q;
  logic signed [Y_WIDTH-1:0]      y1_q, y2_q;
  state_e                         state_q, state_d;
  idx_t                           idx_q, idx_d;
  logic                           flag_q;
  logic                           out_valid_q;
  logic signed [OUT_WIDTH-1:0]    out_data_q;
  logic                           out_sat_q;

  logic                           cfg_write;
  reg_idx_e                       cfg_idx;
  reg_idx_e                       sel_idx;
  logic signed [COEF_WIDTH-1:0]   coef_sel;
  logic signed [Y_WIDTH-1:0]      operand_sel;
  mac_ctrl_t                      mac_ctrl;
  mac_stat_t                      mac_stat;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic                           accept, ystore, oload;
  logic [ACC_WIDTH-Y_WIDTH:0]     y_top;
  logic                           y_ovf;
  logic signed [Y_WIDTH-1:0]      y_sat;
  logic [ACC_WIDTH-OUT_WIDTH:0]   o_top;
  logic                           o_ovf;
  logic signed [OUT_WIDTH-1:0]    o_sat;

  // register bank
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[APB_ADDR_WIDTH-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= RST_B0[COEF_WIDTH-1:0];
      coef_b1_q <= RST_B1[COEF_WIDTH-1:0];
      coef_b2_q <= RST_B2[COEF_WIDTH-1:0];
      coef_a1_q <= RST_A1[COEF_WIDTH-1:0];
      coef_a2_q <= RST_A2[COEF_WIDTH-1:0];
      gain_q    <= RST_GAIN[COEF_WIDTH-1:0];
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_B0:   coef_b0_q <= pwdata[COEF_WIDTH-1:0];
        REG_B1:   coef_b1_q <= pwdata[COEF_WIDTH-1:0];
        REG_B2:   coef_b2_q <= pwdata[COEF_WIDTH-1:0];
        REG_A1:   coef_a1_q <= pwdata[COEF_WIDTH-1:0];
        REG_A2:   coef_a2_q <= pwdata[COEF_WIDTH-1:0];
        REG_GAIN: gain_q    <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_B0:   prdata = APB_DATA_WIDTH'(coef_b0_q);
      REG_B1:   prdata = APB_DATA_WIDTH'(coef_b1_q);
      REG_B2:   prdata = APB_DATA_WIDTH'(coef_b2_q);
      REG_A1:   prdata = APB_DATA_WIDTH'(coef_a1_q);
      REG_A2:   prdata = APB_DATA_WIDTH'(coef_a2_q);
      REG_GAIN: prdata = APB_DATA_WIDTH'(gain_q);
      default:  prdata = '0;
    endcase
  end

  // operand selection for the shared multiplier
  assign sel_idx = (state_q == ST_GAIN) ? REG_GAIN : reg_idx_e'(idx_q[IDX_WIDTH-1:1]);

  always_comb begin
    unique case (sel_idx)
      REG_B0: begin
        coef_sel    = coef_b0_q;
        operand_sel = Y_WIDTH'(x_q);
      end
      REG_B1: begin
        coef_sel    = coef_b1_q;
        operand_sel = Y_WIDTH'(x1_q);
      end
      REG_B2: begin
        coef_sel    = coef_b2_q;
        operand_sel = Y_WIDTH'(x2_q);
      end
      REG_A1: begin
        coef_sel    = coef_a1_q;
        operand_sel = y1_q;
      end
      REG_A2: begin
        coef_sel    = coef_a2_q;
        operand_sel = y2_q;
      end
      default: begin
        coef_sel    = gain_q;
        operand_sel = y1_q;
      end
    endcase
  end

  soiir_mac #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_sel),
    .operand_i(operand_sel),
    .acc_o    (acc),
    .stat_o   (mac_stat)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    mac_ctrl   = '0;
    in_stall_o = 1'b1;
    ystore     = 1'b0;
    oload      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        mac_ctrl.clr_acc = 1'b1;
        if (in_valid_i) begin
          state_d = ST_FILT;
          idx_d   = '0;
        end
      end
      ST_FILT: begin
        mac_ctrl.valid = 1'b1;
        mac_ctrl.half  = idx_q[0];
        if (idx_q == ISSUE_LAST) begin
          state_d = ST_FDRAIN;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      ST_FDRAIN: begin
        if (!mac_stat.busy) begin
          state_d = ST_YSTORE;
        end
      end
      ST_YSTORE: begin
        ystore           = 1'b1;
        mac_ctrl.clr_acc = 1'b1;
        state_d          = ST_GAIN;
      end
      ST_GAIN: begin
        mac_ctrl.valid = 1'b1;
        mac_ctrl.half  = idx_q[0];
        if (idx_q[0]) begin
          state_d = ST_GDRAIN;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      ST_GDRAIN: begin
        if (!mac_stat.busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          oload   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // clip of the sum to the stored output width and of the gained value to the result
  assign y_top = acc[ACC_WIDTH-1:Y_WIDTH-1];
  assign y_ovf = !(&y_top) && (|y_top);
  assign y_sat = !y_ovf ? acc[Y_WIDTH-1:0] :
                 acc[ACC_WIDTH-1] ? {1'b1, {(Y_WIDTH-1){1'b0}}}
                                  : {1'b0, {(Y_WIDTH-1){1'b1}}};

  assign o_top = acc[ACC_WIDTH-1:OUT_WIDTH-1];
  assign o_ovf = !(&o_top) && (|o_top);
  assign o_sat = !o_ovf ? acc[OUT_WIDTH-1:0] :
                 acc[ACC_WIDTH-1] ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                                  : {1'b0, {(OUT_WIDTH-1){1'b1}}};

  // history and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && clear_history_i) begin
        x1_q <= '0;
        x2_q <= '0;
        y1_q <= '0;
        y2_q <= '0;
      end else if (ystore) begin
        x2_q <= x1_q;
        x1_q <= x_q;
        y2_q <= y1_q;
        y1_q <= y_sat;
      end
      if (accept) begin
        flag_q <= 1'b0;
      end else if (mac_stat.ovf || (ystore && y_ovf)) begin
        flag_q <= 1'b1;
      end
      if (oload) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_in_i;
    end
    if (oload) begin
      out_data_q <= o_sat;
      out_sat_q  <= flag_q | o_ovf;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;
  assign saturated_o  = out_sat_q;

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mac_stat.busy)
    else $error("multiplier pipeline busy while idle");

  a_sum_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YSTORE) |-> !mac_stat.busy)
    else $error("sum taken before last term reached the accumulator");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_FILT && idx_q == '0))
    else $error("transfer did not start the filter sequence");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the output step");

endmodule

`default_nettype wire
